### rtl/pmdt_pkg.sv
// Shared types and constants for the planar motion derivative tracker.
// Used by pmdt_ctrl, pmdt_datapath and planar_motion_derivative_tracker.
package pmdt_pkg;

    localparam int AXIS_COUNT = 3;
    localparam int AXIS_W     = 2;
    localparam int POS_W      = 16;
    localparam int VEL_W      = 32;
    localparam int DT_W       = 20;
    localparam int DIFF_W     = VEL_W + 1;
    localparam int SCALE_W    = 21;
    localparam int PROD_W     = DIFF_W + SCALE_W;
    localparam int DIV_STEPS  = PROD_W;
    localparam int DIV_CNT_W  = 6;

    localparam logic signed [SCALE_W-1:0] SCALE_PER_SECOND = 21'sd1000000;

    localparam int PLANE_W = 2;
    localparam logic [PLANE_W-1:0] PLANE_XY = 2'd0;
    localparam logic [PLANE_W-1:0] PLANE_XZ = 2'd1;
    localparam logic [PLANE_W-1:0] PLANE_ZY = 2'd2;

    localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

    localparam logic KIND_VEL = 1'b0;
    localparam logic KIND_ACC = 1'b1;

    localparam int PADDR_W = 3;
    localparam logic REG_PLANE_SELECT = 1'b0;

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 136;

    typedef struct packed {
        logic load;
        logic diff;
        logic mul;
        logic abs_val;
        logic div_step;
        logic fix;
        logic out_load;
        logic slot;
        logic kind;
    } cmd_t;

    // Stored axis that a screen coordinate (slot 0 = x, slot 1 = y) drives.
    function automatic logic [AXIS_W-1:0] axis_map(input logic [PLANE_W-1:0] plane,
                                                   input logic slot);
        logic [AXIS_W-1:0] a;
        case (plane)
            PLANE_XZ: a = slot ? AXIS_Z : AXIS_X;
            PLANE_ZY: a = slot ? AXIS_Y : AXIS_Z;
            default:  a = slot ? AXIS_Y : AXIS_X;
        endcase
        return a;
    endfunction

endpackage

### rtl/planar_motion_derivative_tracker.sv
// Top level of the planar motion derivative tracker: stream ports, APB register.
// Depends on pmdt_pkg, pmdt_ctrl and pmdt_datapath.
//
//  channel   | direction | payload
//  ----------+-----------+---------------------------------------------------
//  s_axis    | in        | cursor_x, cursor_y, elapsed_us
//  m_axis    | out       | velocity_first/second, accel_first/second, saturated
//  apb       | in/out    | plane_select at byte address 0
//
// Each item runs four restoring divisions of 54 quotient bits each, one bit per cycle;
// each value steps through difference, multiply and absolute value, then its division, then the fix.
// Reset clears the axis positions and velocities and selects the XY plane.
// s_axis_tready is high only while no item is in work; a result waiting in the
// output register does not block the next item, only the next result.
module planar_motion_derivative_tracker (
    input  logic                                clk,
    input  logic                                rst_n,
    // [15:0] cursor_x, [31:16] cursor_y, [51:32] elapsed_us, [55:52] zero
    input  logic [pmdt_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [31:0] velocity_first, [63:32] velocity_second, [95:64] accel_first,
    // [127:96] accel_second, [128] saturated, [135:129] zero
    output logic [pmdt_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pmdt_pkg::PADDR_W-1:0]        paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    logic [pmdt_pkg::PLANE_W-1:0] plane_reg;
    pmdt_pkg::cmd_t               cmd;

    logic signed [pmdt_pkg::VEL_W-1:0] velocity_first, velocity_second;
    logic signed [pmdt_pkg::VEL_W-1:0] accel_first, accel_second;
    logic                              saturated;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg <= pmdt_pkg::PLANE_XY;
        end
        else if (psel && penable && pwrite && (paddr[2] == pmdt_pkg::REG_PLANE_SELECT))
        begin
            plane_reg <= pwdata[pmdt_pkg::PLANE_W-1:0];
        end
    end

    assign prdata = (paddr[2] == pmdt_pkg::REG_PLANE_SELECT) ? {30'b0, plane_reg} : 32'b0;

    pmdt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    pmdt_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .plane           (plane_reg),
        .cursor_x        (s_axis_tdata[15:0]),
        .cursor_y        (s_axis_tdata[31:16]),
        .elapsed_us      (s_axis_tdata[51:32]),
        .velocity_first  (velocity_first),
        .velocity_second (velocity_second),
        .accel_first     (accel_first),
        .accel_second    (accel_second),
        .saturated       (saturated)
    );

    assign m_axis_tdata = {7'b0, saturated, accel_second, accel_first,
                           velocity_second, velocity_first};

    // one item at a time: an accepted beat closes the input until the result is built
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while an item is in work");

    // never overwrite a result that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
        else $error("output register loaded over a pending result");

    // a saturated result must carry at least one clamped value
    a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && saturated) |->
            (velocity_first == 32'sh7FFF_FFFF || velocity_first == 32'sh8000_0000 ||
             velocity_second == 32'sh7FFF_FFFF || velocity_second == 32'sh8000_0000 ||
             accel_first == 32'sh7FFF_FFFF || accel_first == 32'sh8000_0000 ||
             accel_second == 32'sh7FFF_FFFF || accel_second == 32'sh8000_0000))
        else $error("saturated flag without a clamped value");

endmodule

### rtl/pmdt_ctrl.sv
// Sequencer for the tracker: handshakes and the per-value step order.
// Depends on pmdt_pkg; drives pmdt_datapath through pmdt_pkg::cmd_t.
module pmdt_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    output pmdt_pkg::cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIFF = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_ABS  = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_FIX  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    localparam logic [pmdt_pkg::DIV_CNT_W-1:0] DIV_LAST =
        pmdt_pkg::DIV_CNT_W'(pmdt_pkg::DIV_STEPS - 1);

    logic [2:0]                     state_reg, state_next;
    logic [1:0]                     op_reg, op_next;
    logic [pmdt_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                           out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.slot       = op_reg[1];
        cmd.kind       = op_reg[0];
        in_ready       = (state_reg == ST_IDLE);

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    op_next    = 2'd0;
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_ABS;
            end
            ST_ABS:
            begin
                cmd.abs_val = 1'b1;
                cnt_next    = '0;
                state_next  = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX:
            begin
                cmd.fix = 1'b1;
                if (op_reg == 2'd3)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    op_next    = op_reg + 1'b1;
                    state_next = ST_DIFF;
                end
            end
            ST_OUT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

### rtl/pmdt_datapath.sv
// Datapath: axis state, difference, scale multiply, restoring divider, clamp.
// Depends on pmdt_pkg; steered by pmdt_ctrl through pmdt_pkg::cmd_t.
module pmdt_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  pmdt_pkg::cmd_t                       cmd,
    input  logic [pmdt_pkg::PLANE_W-1:0]         plane,
    input  logic signed [pmdt_pkg::POS_W-1:0]    cursor_x,
    input  logic signed [pmdt_pkg::POS_W-1:0]    cursor_y,
    input  logic [pmdt_pkg::DT_W-1:0]            elapsed_us,
    output logic signed [pmdt_pkg::VEL_W-1:0]    velocity_first,
    output logic signed [pmdt_pkg::VEL_W-1:0]    velocity_second,
    output logic signed [pmdt_pkg::VEL_W-1:0]    accel_first,
    output logic signed [pmdt_pkg::VEL_W-1:0]    accel_second,
    output logic                                 saturated
);

    localparam int POS_W  = pmdt_pkg::POS_W;
    localparam int VEL_W  = pmdt_pkg::VEL_W;
    localparam int DT_W   = pmdt_pkg::DT_W;
    localparam int DIFF_W = pmdt_pkg::DIFF_W;
    localparam int PROD_W = pmdt_pkg::PROD_W;

    localparam logic [PROD_W-1:0] POS_LIMIT = PROD_W'(64'd2147483647);
    localparam logic [PROD_W-1:0] NEG_LIMIT = PROD_W'(64'd2147483648);
    localparam logic [VEL_W-1:0]  S32_MAX   = 32'h7FFF_FFFF;
    localparam logic [VEL_W-1:0]  S32_MIN   = 32'h8000_0000;

    // stored per-axis state, cleared by reset
    logic signed [POS_W-1:0] axis_pos_reg [pmdt_pkg::AXIS_COUNT];
    logic signed [VEL_W-1:0] axis_vel_reg [pmdt_pkg::AXIS_COUNT];

    // item captured at accept
    logic signed [POS_W-1:0]          pos_in_reg [2];
    logic [pmdt_pkg::AXIS_W-1:0]      ax_reg [2];
    logic [DT_W-1:0]                  dt_reg;

    // per-value working registers
    logic signed [DIFF_W-1:0] diff_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     neg_reg;
    logic [PROD_W-1:0]        num_reg;
    logic [DT_W-1:0]          rem_reg;

    logic signed [VEL_W-1:0]  vres_reg [2];
    logic signed [VEL_W-1:0]  ares_reg [2];
    logic                     sat_reg;

    logic signed [VEL_W-1:0]  out_v0_reg, out_v1_reg, out_a0_reg, out_a1_reg;
    logic                     out_sat_reg;

    logic [pmdt_pkg::AXIS_W-1:0] cur_axis;
    logic signed [DIFF_W-1:0]    diff_next;
    logic [DT_W:0]               rem_shift;
    logic [DT_W:0]               rem_sub;
    logic                        q_bit;
    logic [VEL_W-1:0]            fix_val;
    logic                        fix_sat;

    assign cur_axis = ax_reg[cmd.slot];

    always_comb
    begin
        if (cmd.kind == pmdt_pkg::KIND_VEL)
        begin
            diff_next = DIFF_W'(pos_in_reg[cmd.slot]) - DIFF_W'(axis_pos_reg[cur_axis]);
        end
        else
        begin
            diff_next = DIFF_W'(vres_reg[cmd.slot]) - DIFF_W'(axis_vel_reg[cur_axis]);
        end
    end

    // one restoring step: bring down the next numerator bit
    assign rem_shift = {rem_reg, num_reg[PROD_W-1]};
    assign rem_sub   = rem_shift - {1'b0, dt_reg};
    assign q_bit     = (rem_shift >= {1'b0, dt_reg});

    // sign and clamp the magnitude quotient
    always_comb
    begin
        fix_sat = 1'b0;
        if (neg_reg)
        begin
            if (num_reg > NEG_LIMIT)
            begin
                fix_val = S32_MIN;
                fix_sat = 1'b1;
            end
            else
            begin
                fix_val = (~num_reg[VEL_W-1:0]) + 1'b1;
            end
        end
        else
        begin
            if (num_reg > POS_LIMIT)
            begin
                fix_val = S32_MAX;
                fix_sat = 1'b1;
            end
            else
            begin
                fix_val = num_reg[VEL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < pmdt_pkg::AXIS_COUNT; i++)
            begin
                axis_pos_reg[i] <= '0;
                axis_vel_reg[i] <= '0;
            end
        end
        else if (cmd.fix && (cmd.kind == pmdt_pkg::KIND_ACC))
        begin
            // commit this axis once both its values are known
            axis_pos_reg[cur_axis] <= pos_in_reg[cmd.slot];
            axis_vel_reg[cur_axis] <= vres_reg[cmd.slot];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pos_in_reg[0] <= cursor_x;
            pos_in_reg[1] <= cursor_y;
            ax_reg[0]     <= pmdt_pkg::axis_map(plane, 1'b0);
            ax_reg[1]     <= pmdt_pkg::axis_map(plane, 1'b1);
            dt_reg        <= (elapsed_us == '0) ? DT_W'(1) : elapsed_us;
            sat_reg       <= 1'b0;
        end
        if (cmd.diff)
        begin
            diff_reg <= diff_next;
        end
        if (cmd.mul)
        begin
            prod_reg <= diff_reg * pmdt_pkg::SCALE_PER_SECOND;
        end
        if (cmd.abs_val)
        begin
            neg_reg <= prod_reg[PROD_W-1];
            num_reg <= prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
            rem_reg <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= q_bit ? rem_sub[DT_W-1:0] : rem_shift[DT_W-1:0];
            num_reg <= {num_reg[PROD_W-2:0], q_bit};
        end
        if (cmd.fix)
        begin
            if (cmd.kind == pmdt_pkg::KIND_VEL)
            begin
                vres_reg[cmd.slot] <= fix_val;
            end
            else
            begin
                ares_reg[cmd.slot] <= fix_val;
            end
            sat_reg <= sat_reg | fix_sat;
        end
        if (cmd.out_load)
        begin
            out_v0_reg  <= vres_reg[0];
            out_v1_reg  <= vres_reg[1];
            out_a0_reg  <= ares_reg[0];
            out_a1_reg  <= ares_reg[1];
            out_sat_reg <= sat_reg;
        end
    end

    assign velocity_first  = out_v0_reg;
    assign velocity_second = out_v1_reg;
    assign accel_first     = out_a0_reg;
    assign accel_second    = out_a1_reg;
    assign saturated       = out_sat_reg;

endmodule

### tb/sv/planar_motion_derivative_tracker_tb.sv
// Self-checking testbench for planar_motion_derivative_tracker: stream beats are
// predicted with finite differences in 64-bit arithmetic and compared on output.
// Depends on pmdt_pkg and the planar_motion_derivative_tracker RTL.
module planar_motion_derivative_tracker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int AXIS_COUNT = pmdt_pkg::AXIS_COUNT;
    localparam int AXIS_W     = pmdt_pkg::AXIS_W;
    localparam int POS_W      = pmdt_pkg::POS_W;
    localparam int VEL_W      = pmdt_pkg::VEL_W;
    localparam int DT_W       = pmdt_pkg::DT_W;
    localparam int PLANE_W    = pmdt_pkg::PLANE_W;
    localparam int PADDR_W    = pmdt_pkg::PADDR_W;
    localparam int IN_DATA_W  = pmdt_pkg::IN_DATA_W;
    localparam int OUT_DATA_W = pmdt_pkg::OUT_DATA_W;

    localparam logic [PLANE_W-1:0] PLANE_XY = pmdt_pkg::PLANE_XY;
    localparam logic [PLANE_W-1:0] PLANE_XZ = pmdt_pkg::PLANE_XZ;
    localparam logic [PLANE_W-1:0] PLANE_ZY = pmdt_pkg::PLANE_ZY;
    localparam logic [AXIS_W-1:0]  AXIS_X   = pmdt_pkg::AXIS_X;
    localparam logic [AXIS_W-1:0]  AXIS_Y   = pmdt_pkg::AXIS_Y;
    localparam logic [AXIS_W-1:0]  AXIS_Z   = pmdt_pkg::AXIS_Z;

    localparam longint US_PER_S = 64'sd1000000;
    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    localparam logic [PADDR_W-1:0] ADDR_PLANE = PADDR_W'(4 * pmdt_pkg::REG_PLANE_SELECT);
    localparam logic [PADDR_W-1:0] ADDR_SPARE = PADDR_W'(4);   // no register here
    localparam logic [PLANE_W-1:0] PLANE_SPARE = 2'd3;          // unused code, acts as XY

    localparam int RANDOM_ITEMS = 400;
    localparam int PHASE_LEN    = 50;
    localparam int DRAIN_CYCLES = 500;
    localparam int HOLD_CYCLES  = 2000;
    localparam int HOLD_AFTER   = 140;

    typedef struct packed {
        logic [DT_W-1:0]          dt;
        logic signed [POS_W-1:0]  y;
        logic signed [POS_W-1:0]  x;
    } sample_t;

    typedef struct packed {
        logic                     sat;
        logic signed [VEL_W-1:0]  acc_second;
        logic signed [VEL_W-1:0]  acc_first;
        logic signed [VEL_W-1:0]  vel_second;
        logic signed [VEL_W-1:0]  vel_first;
    } motion_t;

    typedef struct packed {
        bit                       wr;
        logic [PADDR_W-1:0]       addr;
        logic [31:0]              wdata;
        logic signed [POS_W-1:0]  x;
        logic signed [POS_W-1:0]  y;
        logic [DT_W-1:0]          dt;
        bit                       typed;
        motion_t                  want;
    } drive_row_t;

    localparam motion_t MOTION_REST = '0;
    localparam motion_t MOTION_PEG_XP = '{sat: 1'b1, acc_second: S32_MIN, acc_first: S32_MAX,
                                          vel_second: S32_MIN, vel_first: S32_MAX};
    localparam motion_t MOTION_PEG_XN = '{sat: 1'b1, acc_second: S32_MAX, acc_first: S32_MIN,
                                          vel_second: S32_MAX, vel_first: S32_MIN};

    logic                   clk;
    logic                   rst_n;
    logic [IN_DATA_W-1:0]   s_axis_tdata;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [PADDR_W-1:0]     paddr;
    logic [31:0]            pwdata;
    logic [31:0]            prdata;
    logic                   pready;

    // Predictor state
    logic [PLANE_W-1:0]       plane_shadow;
    logic signed [POS_W-1:0]  axis_pos [AXIS_COUNT];
    logic signed [VEL_W-1:0]  axis_vel [AXIS_COUNT];

    motion_t motion_q [$];
    int      n_errors;
    int      n_results;

    drive_row_t dir_rows [18] = '{
        '{1'b0, ADDR_PLANE, 32'd0, 16'sd0, 16'sd0, 20'd0, 1'b1, MOTION_REST},
        '{1'b0, ADDR_PLANE, 32'd0, 16'sd32767, -16'sd32768, 20'd0, 1'b1, MOTION_PEG_XP},
        '{1'b0, ADDR_PLANE, 32'd0, -16'sd32768, 16'sd32767, 20'd1, 1'b1, MOTION_PEG_XN},
        '{1'b0, ADDR_PLANE, 32'd0, -16'sd32768, 16'sd32767, 20'hFFFFF, 1'b0, MOTION_REST},
        '{1'b0, ADDR_PLANE, 32'd0, 16'sd100, -16'sd100, 20'd1000, 1'b0, MOTION_REST},
        '{1'b0, ADDR_PLANE, 32'd0, 16'sd101, -16'sd99, 20'd1000, 1'b0, MOTION_REST},
        '{1'b0, ADDR_PLANE, 32'd0, -16'sd1, 16'sd1, 20'h80000, 1'b0, MOTION_REST},
        '{1'b1, ADDR_PLANE, 32'(PLANE_XZ), 16'sd10, 16'sd20, 20'd500, 1'b0, MOTION_REST},
        '{1'b0, ADDR_PLANE, 32'd0, 16'sd15, 16'sd10, 20'd500, 1'b0, MOTION_REST},
        '{1'b1, ADDR_PLANE, 32'(PLANE_ZY), -16'sd7, 16'sd3, 20'd250, 1'b0, MOTION_REST},
        '{1'b0, ADDR_PLANE, 32'd0, -16'sd9, 16'sd6, 20'd250, 1'b0, MOTION_REST},
        '{1'b1, ADDR_PLANE, 32'(PLANE_SPARE), 16'sd1, 16'sd2, 20'd2000, 1'b0, MOTION_REST},
        '{1'b0, ADDR_PLANE, 32'd0, 16'sd0, 16'sd0, 20'd2000, 1'b0, MOTION_REST},
        '{1'b1, ADDR_SPARE, 32'(PLANE_ZY), 16'sd3, -16'sd3, 20'd100, 1'b0, MOTION_REST},
        '{1'b0, ADDR_PLANE, 32'd0, 16'sd4, -16'sd2, 20'd100, 1'b0, MOTION_REST},
        '{1'b1, ADDR_PLANE, 32'(PLANE_XY), -16'sd32768, -16'sd32768, 20'd0, 1'b0, MOTION_REST},
        '{1'b0, ADDR_PLANE, 32'd0, 16'sd32767, 16'sd32767, 20'hFFFFF, 1'b0, MOTION_REST},
        '{1'b0, ADDR_PLANE, 32'd0, 16'sd32767, 16'sd32767, 20'd3, 1'b0, MOTION_REST}
    };

    planar_motion_derivative_tracker u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic longint clamp_s32(input longint v, inout logic sat);
        if (v > longint'(S32_MAX))
        begin
            sat = 1'b1;
            return longint'(S32_MAX);
        end
        if (v < longint'(S32_MIN))
        begin
            sat = 1'b1;
            return longint'(S32_MIN);
        end
        return v;
    endfunction

    // Advance the tracker state by one sample and return the derivatives it yields.
    function automatic motion_t track_step(input sample_t s);
        logic [AXIS_W-1:0] ax [2];
        longint pos [2];
        longint vel [2];
        longint acc [2];
        longint span;
        longint dv;
        logic sat;
        motion_t r;
        sat = 1'b0;
        span = (s.dt == '0) ? 64'sd1 : longint'(s.dt);
        pos[0] = longint'($signed(s.x));
        pos[1] = longint'($signed(s.y));
        case (plane_shadow)
            PLANE_XZ:
            begin
                ax[0] = AXIS_X;
                ax[1] = AXIS_Z;
            end
            PLANE_ZY:
            begin
                ax[0] = AXIS_Z;
                ax[1] = AXIS_Y;
            end
            default:
            begin
                ax[0] = AXIS_X;
                ax[1] = AXIS_Y;
            end
        endcase
        for (int k = 0; k < 2; k++)
        begin
            vel[k] = clamp_s32((pos[k] - longint'(axis_pos[ax[k]])) * US_PER_S / span, sat);
            dv = vel[k] - longint'(axis_vel[ax[k]]);
            acc[k] = clamp_s32(dv * US_PER_S / span, sat);
        end
        for (int k = 0; k < 2; k++)
        begin
            axis_pos[ax[k]] = POS_W'(pos[k]);
            axis_vel[ax[k]] = VEL_W'(vel[k]);
        end
        r.vel_first  = VEL_W'(vel[0]);
        r.vel_second = VEL_W'(vel[1]);
        r.acc_first  = VEL_W'(acc[0]);
        r.acc_second = VEL_W'(acc[1]);
        r.sat        = sat;
        return r;
    endfunction

    function automatic logic signed [POS_W-1:0] nudge(input logic signed [POS_W-1:0] p,
                                                      input int step);
        int t;
        t = int'(p) + step;
        if (t > 32767)
            t = 32767;
        if (t < -32768)
            t = -32768;
        return POS_W'(t);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 5);
        if (r < 97)
            return $urandom_range(6, 30);
        return $urandom_range(50, 200);
    endfunction

    task automatic report_mismatch(input string what, input motion_t want, input motion_t got);
        n_errors++;
        if (n_errors <= 10)
        begin
            $display("%0t mismatch (%s): want vel %0d/%0d acc %0d/%0d sat %0b",
                     $realtime, what,
                     $signed(want.vel_first), $signed(want.vel_second),
                     $signed(want.acc_first), $signed(want.acc_second), want.sat);
            $display("    got vel %0d/%0d acc %0d/%0d sat %0b pad %0h",
                     $signed(got.vel_first), $signed(got.vel_second),
                     $signed(got.acc_first), $signed(got.acc_second), got.sat,
                     m_axis_tdata[OUT_DATA_W-1:129]);
        end
    endtask

    // Offer one beat, hold it until accepted, then queue its expected result.
    task automatic send_sample(input sample_t s, input bit typed, input motion_t typed_want);
        int gap;
        motion_t predicted;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata  <= {{(IN_DATA_W - $bits(sample_t)){1'b0}}, s};
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        predicted = track_step(s);
        motion_q.push_back(typed ? typed_want : predicted);
    endtask

    // Drop valid, drain every pending result, then do one APB write.
    task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (motion_q.size() != 0)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (addr == ADDR_PLANE)
            plane_shadow = data[PLANE_W-1:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    always @(posedge clk)
    begin : result_check
        motion_t got;
        motion_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[128:0];
            n_results++;
            if (motion_q.size() == 0)
                report_mismatch("unexpected beat", MOTION_REST, got);
            else
            begin
                want = motion_q.pop_front();
                if (got.vel_first !== want.vel_first || got.vel_second !== want.vel_second
                    || got.acc_first !== want.acc_first || got.acc_second !== want.acc_second
                    || got.sat !== want.sat || m_axis_tdata[OUT_DATA_W-1:129] !== '0)
                    report_mismatch("fields", want, got);
            end
        end
    end

    // Receiver: random back-pressure, plus one long hold-off to fill the block.
    initial
    begin : sink_pacing
        int r;
        bit held_off;
        held_off = 1'b0;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            r = $urandom_range(0, 99);
            if (!held_off && n_results >= HOLD_AFTER)
            begin
                held_off = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else if (r < 55)
            begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(negedge clk);
            end
            else if (r < 92)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(negedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(20, 300)) @(negedge clk);
            end
        end
    end

    initial
    begin : stimulus
        int i;
        int pick;
        sample_t s;
        logic signed [POS_W-1:0] trail_x;
        logic signed [POS_W-1:0] trail_y;

        rst_n         = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tvalid = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        n_errors      = 0;
        n_results     = 0;
        plane_shadow  = PLANE_XY;
        for (i = 0; i < AXIS_COUNT; i++)
        begin
            axis_pos[i] = '0;
            axis_vel[i] = '0;
        end
        trail_x = '0;
        trail_y = '0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[r])
        begin
            if (dir_rows[r].wr)
                write_reg(dir_rows[r].addr, dir_rows[r].wdata);
            s = '{dt: dir_rows[r].dt, y: dir_rows[r].y, x: dir_rows[r].x};
            send_sample(s, dir_rows[r].typed, dir_rows[r].want);
        end

        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % PHASE_LEN == 0)
            begin
                if ($urandom_range(0, 3) == 0)
                    write_reg(ADDR_SPARE, $urandom);
                write_reg(ADDR_PLANE, 32'($urandom_range(0, 3)));
            end
            pick = $urandom_range(0, 99);
            if (pick < 65)
            begin
                // smooth hand motion at roughly kilohertz sample rates
                s.x  = nudge(trail_x, int'($urandom_range(0, 400)) - 200);
                s.y  = nudge(trail_y, int'($urandom_range(0, 400)) - 200);
                s.dt = DT_W'($urandom_range(200, 20000));
            end
            else if (pick < 80)
            begin
                s.x  = POS_W'($urandom);
                s.y  = POS_W'($urandom);
                s.dt = DT_W'($urandom);
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0:       s.dt = '0;
                    1:       s.dt = DT_W'(1);
                    2:       s.dt = '1;
                    default: s.dt = DT_W'($urandom_range(2, 10));
                endcase
                case ($urandom_range(0, 3))
                    0:       s.x = 16'sh7FFF;
                    1:       s.x = 16'sh8000;
                    2:       s.x = '0;
                    default: s.x = POS_W'($urandom);
                endcase
                case ($urandom_range(0, 3))
                    0:       s.y = 16'sh7FFF;
                    1:       s.y = 16'sh8000;
                    2:       s.y = '0;
                    default: s.y = POS_W'($urandom);
                endcase
            end
            trail_x = s.x;
            trail_y = s.y;
            send_sample(s, 1'b0, MOTION_REST);
        end

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (motion_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (n_errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### planar_motion_derivative_tracker.f
rtl/pmdt_pkg.sv
rtl/pmdt_ctrl.sv
rtl/pmdt_datapath.sv
rtl/planar_motion_derivative_tracker.sv
tb/sv/planar_motion_derivative_tracker_tb.sv
